[rtl/brt_pkg.sv]
// brt_pkg: shared constants, opcodes, status codes and sequencer types
// for the binary trie route table. No dependencies.
package brt_pkg;

    localparam int NODE_COUNT_DEF   = 4096;
    localparam int PEER_BITS_DEF    = 16;
    localparam int MAX_KEY_BITS_DEF = 128;

    localparam int KEY_W   = 128;
    localparam int HALF_W  = 64;
    localparam int V4_BITS = 32;
    localparam int DEPTH_W = 8;
    localparam int OP_W    = 2;
    localparam int PLEN_W  = 8;
    localparam int STAT_W  = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BADLEN  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_INS_WALK,
        ST_ALLOC,
        ST_ALLOC_GOT,
        ST_INS_LINK,
        ST_LOOKUP,
        ST_RM_DOWN,
        ST_PRUNE,
        ST_PRUNE_PS,
        ST_PRUNE_CLR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic take;
        logic give;
        logic clear;
    } pool_ctrl_t;

endpackage

[rtl/brt_pool.sv]
// brt_pool: node allocator, a recycle stack in memory plus a fresh-index counter.
// Depends on brt_pkg.
module brt_pool #(
    parameter int NODE_COUNT = brt_pkg::NODE_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  brt_pkg::pool_ctrl_t           ctrl,
    input  logic [$clog2(NODE_COUNT)-1:0] give_idx,
    output logic                          empty,
    output logic [$clog2(NODE_COUNT)-1:0] take_idx
);

    localparam int IDX_W = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(NODE_COUNT + 1);

    logic [IDX_W-1:0] stack_mem [NODE_COUNT];

    logic [CNT_W-1:0] rc_reg;
    logic [CNT_W-1:0] fresh_reg;
    logic             from_stack_reg;
    logic [IDX_W-1:0] stack_rd_reg;
    logic [IDX_W-1:0] fresh_q_reg;
    logic [CNT_W-1:0] rc_dec;

    assign rc_dec   = rc_reg - CNT_W'(1);
    assign empty    = (rc_reg == '0) && (fresh_reg == CNT_W'(NODE_COUNT));
    assign take_idx = from_stack_reg ? stack_rd_reg : fresh_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg         <= '0;
            fresh_reg      <= '0;
            from_stack_reg <= 1'b0;
        end
        else
        begin
            priority if (ctrl.clear)
            begin
                rc_reg    <= '0;
                fresh_reg <= '0;
            end
            else if (ctrl.take)
            begin
                if (rc_reg != '0)
                begin
                    rc_reg         <= rc_dec;
                    from_stack_reg <= 1'b1;
                end
                else
                begin
                    fresh_reg      <= fresh_reg + CNT_W'(1);
                    from_stack_reg <= 1'b0;
                end
            end
            else if (ctrl.give)
            begin
                rc_reg <= rc_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take && (rc_reg != '0))
        begin
            stack_rd_reg <= stack_mem[rc_dec[IDX_W-1:0]];
        end
        if (ctrl.take)
        begin
            fresh_q_reg <= fresh_reg[IDX_W-1:0];
        end
        if (ctrl.give && !ctrl.clear)
        begin
            stack_mem[rc_reg[IDX_W-1:0]] <= give_idx;
        end
    end

endmodule

[rtl/binary_trie_prefix_route_table_top.sv]
// Binary trie route table: one memory step per trie level, one word at a time.
// Insert walks to the prefix length and allocates each missing node (root included);
// lookup walks up to key_bits levels; remove walks to plen and prunes emptied nodes; clear resets the pool.
// Not ready while busy: next word is taken in the cycle after the result loads, plus result stall.
// The node memory, with one read port and one write port, sets the rate.
// Reset (rst_n low, async): empty table, 32-bit keys, no clearing pass.
module binary_trie_prefix_route_table_top #(
    parameter int NODE_COUNT   = brt_pkg::NODE_COUNT_DEF,
    parameter int PEER_BITS    = brt_pkg::PEER_BITS_DEF,
    parameter int MAX_KEY_BITS = brt_pkg::MAX_KEY_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // opcode, addr_hi, addr_lo, prefix_len, peer_in
    input  logic [((brt_pkg::OP_W + 2*brt_pkg::HALF_W + brt_pkg::PLEN_W + PEER_BITS + 7) / 8)
                  * 8 - 1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // status, found, peer_out
    output logic [((brt_pkg::STAT_W + 1 + PEER_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data
);

    localparam int IDX_W    = $clog2(NODE_COUNT);
    localparam int LINK_W   = IDX_W + 1;
    localparam int ENT_W    = 2 * LINK_W + 1 + PEER_BITS;
    localparam int PS_DEPTH = MAX_KEY_BITS + 1;
    localparam int PS_AW    = $clog2(PS_DEPTH);
    localparam int PS_W     = IDX_W + 1;
    localparam int KEY_W    = brt_pkg::KEY_W;
    localparam int DEPTH_W  = brt_pkg::DEPTH_W;
    localparam int OUT_W    = ((brt_pkg::STAT_W + 1 + PEER_BITS + 7) / 8) * 8;
    localparam int HI_LSB   = brt_pkg::OP_W;
    localparam int LO_LSB   = HI_LSB + brt_pkg::HALF_W;
    localparam int PL_LSB   = LO_LSB + brt_pkg::HALF_W;
    localparam int PEER_LSB = PL_LSB + brt_pkg::PLEN_W;

    localparam logic [LINK_W-1:0] NO_LINK   = LINK_W'(NODE_COUNT);
    localparam logic [ENT_W-1:0]  EMPTY_ENT = {NO_LINK, NO_LINK, 1'b0, PEER_BITS'(0)};

    logic [ENT_W-1:0] node_mem [NODE_COUNT];
    logic [PS_W-1:0]  ps_mem [PS_DEPTH];

    brt_pkg::state_t state_reg, state_next;

    logic                        use_rd_reg, use_rd_next;
    logic                        root_present_reg, root_present_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        ipv6_reg;
    logic [brt_pkg::OP_W-1:0]    op_reg, op_next;
    logic [KEY_W-1:0]            key_reg, key_next;
    logic [DEPTH_W-1:0]          cnt_reg, cnt_next;
    logic [DEPTH_W-1:0]          len_reg, len_next;
    logic [brt_pkg::PLEN_W-1:0]  plen_reg, plen_next;
    logic [PEER_BITS-1:0]        peer_reg, peer_next;
    logic [IDX_W-1:0]            cur_reg, cur_next;
    logic [IDX_W-1:0]            new_reg, new_next;
    logic [IDX_W-1:0]            root_idx_reg, root_idx_next;
    logic [ENT_W-1:0]            cur_ent_reg, cur_ent_next;
    logic                        bit_reg, bit_next;
    logic                        ret_root_reg, ret_root_next;
    logic [brt_pkg::STAT_W-1:0]  status_reg, status_next;
    logic                        found_reg, found_next;
    logic [PEER_BITS-1:0]        pout_reg, pout_next;
    logic [brt_pkg::STAT_W-1:0]  out_status_reg, out_status_next;
    logic                        out_found_reg, out_found_next;
    logic [PEER_BITS-1:0]        out_peer_reg, out_peer_next;

    logic [ENT_W-1:0] node_rd_reg;
    logic [PS_W-1:0]  ps_rd_reg;

    logic             node_we, node_re;
    logic [IDX_W-1:0] node_waddr, node_raddr;
    logic [ENT_W-1:0] node_wdata;
    logic             ps_we, ps_re;
    logic [PS_AW-1:0] ps_waddr, ps_raddr;
    logic [PS_W-1:0]  ps_wdata;

    brt_pkg::pool_ctrl_t pool_ctrl;
    logic                pool_empty;
    logic [IDX_W-1:0]    pool_idx;

    logic [ENT_W-1:0]   ent;
    logic [PEER_BITS-1:0] ent_peer;
    logic               ent_route;
    logic [LINK_W-1:0]  ent_zero, ent_one;
    logic               key_bit;
    logic [LINK_W-1:0]  nxt;
    logic               nxt_none;
    logic [DEPTH_W-1:0] kb;
    logic [DEPTH_W-1:0] cnt_dec;
    logic [DEPTH_W-1:0] plen_ext;
    logic               leaf;
    logic               s_acc;

    assign s_acc     = s_tvalid && s_tready;
    assign s_tready  = (state_reg == brt_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_W'({out_peer_reg, out_found_reg, out_status_reg});

    assign ent       = use_rd_reg ? node_rd_reg : cur_ent_reg;
    assign ent_peer  = ent[PEER_BITS-1:0];
    assign ent_route = ent[PEER_BITS];
    assign ent_zero  = ent[PEER_BITS+1 +: LINK_W];
    assign ent_one   = ent[PEER_BITS+1+LINK_W +: LINK_W];
    assign key_bit   = key_reg[KEY_W-1];
    assign nxt       = key_bit ? ent_one : ent_zero;
    assign nxt_none  = (nxt == NO_LINK);
    assign kb        = ipv6_reg ? DEPTH_W'(MAX_KEY_BITS) : DEPTH_W'(brt_pkg::V4_BITS);
    assign cnt_dec   = cnt_reg - DEPTH_W'(1);
    assign plen_ext  = DEPTH_W'(plen_reg);
    assign leaf      = (ent_zero == NO_LINK) && (ent_one == NO_LINK) && !ent_route;

    brt_pool #(
        .NODE_COUNT(NODE_COUNT)
    ) u_pool (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (pool_ctrl),
        .give_idx (cur_reg),
        .empty    (pool_empty),
        .take_idx (pool_idx)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            brt_pkg::ST_IDLE:
            begin
                if (s_acc)
                begin
                    state_next = brt_pkg::ST_START;
                end
            end
            brt_pkg::ST_START:
            begin
                unique case (op_reg)
                    brt_pkg::OP_INSERT:
                        state_next = root_present_reg ? brt_pkg::ST_INS_WALK
                                                      : brt_pkg::ST_ALLOC;
                    brt_pkg::OP_LOOKUP:
                        state_next = root_present_reg ? brt_pkg::ST_LOOKUP
                                                      : brt_pkg::ST_DONE;
                    brt_pkg::OP_REMOVE:
                        state_next = (plen_ext > kb || !root_present_reg) ? brt_pkg::ST_DONE
                                                                          : brt_pkg::ST_RM_DOWN;
                    default:
                        state_next = brt_pkg::ST_DONE;
                endcase
            end
            brt_pkg::ST_INS_WALK:
            begin
                priority if (cnt_reg == len_reg)
                    state_next = brt_pkg::ST_DONE;
                else if (nxt_none)
                    state_next = brt_pkg::ST_ALLOC;
            end
            brt_pkg::ST_ALLOC:
                state_next = pool_empty ? brt_pkg::ST_DONE : brt_pkg::ST_ALLOC_GOT;
            brt_pkg::ST_ALLOC_GOT:
                state_next = brt_pkg::ST_INS_LINK;
            brt_pkg::ST_INS_LINK:
                state_next = brt_pkg::ST_INS_WALK;
            brt_pkg::ST_LOOKUP:
            begin
                if (cnt_reg == kb || nxt_none)
                begin
                    state_next = brt_pkg::ST_DONE;
                end
            end
            brt_pkg::ST_RM_DOWN:
            begin
                if (!(cnt_reg < plen_ext && !nxt_none))
                begin
                    state_next = brt_pkg::ST_PRUNE;
                end
            end
            brt_pkg::ST_PRUNE:
                state_next = (!leaf || cnt_reg == '0) ? brt_pkg::ST_DONE
                                                     : brt_pkg::ST_PRUNE_PS;
            brt_pkg::ST_PRUNE_PS:
                state_next = brt_pkg::ST_PRUNE_CLR;
            brt_pkg::ST_PRUNE_CLR:
                state_next = brt_pkg::ST_PRUNE;
            brt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = brt_pkg::ST_IDLE;
                end
            end
            default:
                state_next = brt_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        use_rd_next       = use_rd_reg;
        root_present_next = root_present_reg;
        out_valid_next    = out_valid_reg;
        op_next           = op_reg;
        key_next          = key_reg;
        cnt_next          = cnt_reg;
        len_next          = len_reg;
        plen_next         = plen_reg;
        peer_next         = peer_reg;
        cur_next          = cur_reg;
        new_next          = new_reg;
        root_idx_next     = root_idx_reg;
        cur_ent_next      = cur_ent_reg;
        bit_next          = bit_reg;
        ret_root_next     = ret_root_reg;
        status_next       = status_reg;
        found_next        = found_reg;
        pout_next         = pout_reg;
        out_status_next   = out_status_reg;
        out_found_next    = out_found_reg;
        out_peer_next     = out_peer_reg;
        node_we    = 1'b0;
        node_waddr = cur_reg;
        node_wdata = ent;
        node_re    = 1'b0;
        node_raddr = nxt[IDX_W-1:0];
        ps_we      = 1'b0;
        ps_waddr   = cnt_reg[PS_AW-1:0];
        ps_wdata   = {cur_reg, key_bit};
        ps_re      = 1'b0;
        ps_raddr   = cnt_dec[PS_AW-1:0];
        pool_ctrl  = '0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            brt_pkg::ST_IDLE:
            begin
                if (s_acc)
                begin
                    op_next     = s_tdata[brt_pkg::OP_W-1:0];
                    key_next    = {s_tdata[HI_LSB +: brt_pkg::HALF_W],
                                   s_tdata[LO_LSB +: brt_pkg::HALF_W]};
                    plen_next   = s_tdata[PL_LSB +: brt_pkg::PLEN_W];
                    peer_next   = s_tdata[PEER_LSB +: PEER_BITS];
                    status_next = brt_pkg::STAT_OK;
                    found_next  = 1'b0;
                    pout_next   = '0;
                end
            end
            brt_pkg::ST_START:
            begin
                cnt_next      = '0;
                len_next      = (plen_ext > kb) ? kb : plen_ext;
                ret_root_next = 1'b1;
                cur_next      = root_idx_reg;
                node_raddr    = root_idx_reg;
                unique case (op_reg)
                    brt_pkg::OP_INSERT, brt_pkg::OP_LOOKUP:
                    begin
                        node_re     = root_present_reg;
                        use_rd_next = 1'b1;
                    end
                    brt_pkg::OP_REMOVE:
                    begin
                        if (plen_ext > kb)
                        begin
                            status_next = brt_pkg::STAT_BADLEN;
                        end
                        else
                        begin
                            node_re = root_present_reg;
                        end
                        use_rd_next = 1'b1;
                    end
                    default:
                    begin
                        pool_ctrl.clear   = 1'b1;
                        root_present_next = 1'b0;
                    end
                endcase
            end
            brt_pkg::ST_INS_WALK:
            begin
                priority if (cnt_reg == len_reg)
                begin
                    found_next = ent_route;
                    pout_next  = ent_peer;
                    node_we    = 1'b1;
                    node_wdata = {ent_one, ent_zero, 1'b1, peer_reg};
                end
                else if (!nxt_none)
                begin
                    node_re     = 1'b1;
                    cur_next    = nxt[IDX_W-1:0];
                    cnt_next    = cnt_reg + DEPTH_W'(1);
                    key_next    = {key_reg[KEY_W-2:0], 1'b0};
                    use_rd_next = 1'b1;
                end
                else
                begin
                    cur_ent_next  = ent;
                    use_rd_next   = 1'b0;
                    ret_root_next = 1'b0;
                end
            end
            brt_pkg::ST_ALLOC:
            begin
                if (pool_empty)
                begin
                    status_next = brt_pkg::STAT_NOSPACE;
                end
                else
                begin
                    pool_ctrl.take = 1'b1;
                end
            end
            brt_pkg::ST_ALLOC_GOT:
            begin
                node_we    = 1'b1;
                node_waddr = pool_idx;
                node_wdata = EMPTY_ENT;
                new_next   = pool_idx;
            end
            brt_pkg::ST_INS_LINK:
            begin
                if (ret_root_reg)
                begin
                    root_idx_next     = new_reg;
                    root_present_next = 1'b1;
                end
                else
                begin
                    node_we    = 1'b1;
                    node_wdata = key_bit ? {LINK_W'(new_reg), ent_zero, ent_route, ent_peer}
                                         : {ent_one, LINK_W'(new_reg), ent_route, ent_peer};
                    cnt_next   = cnt_reg + DEPTH_W'(1);
                    key_next   = {key_reg[KEY_W-2:0], 1'b0};
                end
                cur_next     = new_reg;
                cur_ent_next = EMPTY_ENT;
                use_rd_next  = 1'b0;
            end
            brt_pkg::ST_LOOKUP:
            begin
                if (ent_route)
                begin
                    found_next = 1'b1;
                    pout_next  = ent_peer;
                end
                if (cnt_reg != kb && !nxt_none)
                begin
                    node_re  = 1'b1;
                    cur_next = nxt[IDX_W-1:0];
                    cnt_next = cnt_reg + DEPTH_W'(1);
                    key_next = {key_reg[KEY_W-2:0], 1'b0};
                end
            end
            brt_pkg::ST_RM_DOWN:
            begin
                if (cnt_reg < plen_ext && !nxt_none)
                begin
                    ps_we    = 1'b1;
                    node_re  = 1'b1;
                    cur_next = nxt[IDX_W-1:0];
                    cnt_next = cnt_reg + DEPTH_W'(1);
                    key_next = {key_reg[KEY_W-2:0], 1'b0};
                end
                else
                begin
                    if (cnt_reg == plen_ext)
                    begin
                        found_next   = ent_route;
                        pout_next    = ent_peer;
                        node_we      = 1'b1;
                        node_wdata   = {ent_one, ent_zero, 1'b0, PEER_BITS'(0)};
                        cur_ent_next = {ent_one, ent_zero, 1'b0, PEER_BITS'(0)};
                    end
                    else
                    begin
                        cur_ent_next = ent;
                    end
                    use_rd_next = 1'b0;
                end
            end
            brt_pkg::ST_PRUNE:
            begin
                if (leaf)
                begin
                    pool_ctrl.give = 1'b1;
                    if (cnt_reg == '0)
                    begin
                        root_present_next = 1'b0;
                    end
                    else
                    begin
                        ps_re    = 1'b1;
                        cnt_next = cnt_dec;
                    end
                end
            end
            brt_pkg::ST_PRUNE_PS:
            begin
                node_re     = 1'b1;
                node_raddr  = ps_rd_reg[PS_W-1:1];
                cur_next    = ps_rd_reg[PS_W-1:1];
                bit_next    = ps_rd_reg[0];
                use_rd_next = 1'b1;
            end
            brt_pkg::ST_PRUNE_CLR:
            begin
                node_we      = 1'b1;
                node_wdata   = bit_reg ? {NO_LINK, ent_zero, ent_route, ent_peer}
                                       : {ent_one, NO_LINK, ent_route, ent_peer};
                cur_ent_next = node_wdata;
                use_rd_next  = 1'b0;
            end
            brt_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_found_next  = found_reg;
                    out_peer_next   = found_reg ? pout_reg : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= brt_pkg::ST_IDLE;
            use_rd_reg       <= 1'b0;
            root_present_reg <= 1'b0;
            root_idx_reg     <= '0;
            out_valid_reg    <= 1'b0;
            ipv6_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            use_rd_reg       <= use_rd_next;
            root_present_reg <= root_present_next;
            root_idx_reg     <= root_idx_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                ipv6_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        cnt_reg        <= cnt_next;
        len_reg        <= len_next;
        plen_reg       <= plen_next;
        peer_reg       <= peer_next;
        cur_reg        <= cur_next;
        new_reg        <= new_next;
        cur_ent_reg    <= cur_ent_next;
        bit_reg        <= bit_next;
        ret_root_reg   <= ret_root_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        pout_reg       <= pout_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_peer_reg   <= out_peer_next;
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_waddr] <= node_wdata;
        end
        if (node_re)
        begin
            node_rd_reg <= node_mem[node_raddr];
        end
        if (ps_we)
        begin
            ps_mem[ps_waddr] <= ps_wdata;
        end
        if (ps_re)
        begin
            ps_rd_reg <= ps_mem[ps_raddr];
        end
    end

`ifndef SYNTHESIS
    a_pool_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(pool_ctrl.take && pool_ctrl.give))
        else $error("pool take and give together");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == brt_pkg::ST_DONE))
        else $error("result word loaded outside done");

    a_badlen_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == brt_pkg::ST_DONE && status_reg == brt_pkg::STAT_BADLEN)
        |-> (op_reg == brt_pkg::OP_REMOVE))
        else $error("length error on non-remove");
`endif

endmodule
